FILE: sv/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

   // Position within the 3-byte group.
   localparam logic [1:0] PH_0 = 2'd0;
   localparam logic [1:0] PH_1 = 2'd1;
   localparam logic [1:0] PH_2 = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam int QUEUE_DEPTH = 2;

   // Up to four characters caused by one byte; cnt holds count minus one.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      cnt;
      logic            last;
   } b64e_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } b64e_qstat_type;

   // Standard alphabet: A-Z a-z 0-9 + /
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = 8'h41 + w;
      end else if (v < 6'd52) begin
         c = 8'h61 + w - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + w - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: sv/base64_encoder.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data_byte[7:0], req_final_byte
// rsp_      out        rsp_valid / rsp_ready  rsp_out_char[7:0], rsp_out_last
//
// A byte is taken in the cycle it arrives whenever the job queue has space;
// the front computes all 1..4 characters of that byte at once.
// The back sends one character per cycle while rsp_ready holds, from a registered
// output stage, so a byte yields 1 to 4 characters (4 per 3 bytes over a full group,
// more at the end of a message); the output serialiser sets the sustained rate.
// Synchronous active-high reset clears group state, queue and output valid.
// Output stalls fill the queue and then drop req_ready; no item is lost.
module base64_encoder #(
   parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_out_last
);
   import b64e_pkg::*;

   // front -> queue
   logic           push;
   b64e_job_type   push_job;
   // queue -> back
   b64e_job_type   head_job;
   b64e_qstat_type qstat;
   logic           pop;

   // Front: group phase and leftover bits, classifies each byte into a job.
   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .qstat          (qstat),
      .push           (push),
      .push_job       (push_job)
   );

   // Short job queue decoupling intake from character output.
   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // Back: walks the head job one character per cycle, while the output slot is free, into the output register.
   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule
`default_nettype wire

FILE: sv/b64e_front.sv
`default_nettype none
module b64e_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_final_byte,
   input  wire b64e_pkg::b64e_qstat_type qstat,
   output logic                        push,
   output b64e_pkg::b64e_job_type      push_job
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] pend_ff, pend_in;
   logic [1:0] next_phase;
   logic [3:0] next_pend;
   logic       accept;
   b64e_job_type job;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      job.chars  = {4{PAD_CHAR}};
      job.cnt    = 2'd0;
      job.last   = req_final_byte;
      next_phase = PH_1;
      next_pend  = {2'b00, req_data_byte[1:0]};
      unique case (phase_ff)
         PH_1: begin
            job.chars[0] = sextet_char({pend_ff[1:0], req_data_byte[7:4]});
            next_pend    = req_data_byte[3:0];
            next_phase   = PH_2;
         end
         PH_2: begin
            job.chars[0] = sextet_char({pend_ff, req_data_byte[7:6]});
            job.chars[1] = sextet_char(req_data_byte[5:0]);
            job.cnt      = 2'd1;
            next_pend    = 4'd0;
            next_phase   = PH_0;
         end
         default: begin
            // phase 3 cannot arise; handled as start of group
            job.chars[0] = sextet_char(req_data_byte[7:2]);
         end
      endcase
      if (req_final_byte) begin
         if (next_phase == PH_1) begin
            job.chars[1] = sextet_char({next_pend[1:0], 4'b0000});
            job.cnt      = 2'd3;
         end else if (next_phase == PH_2) begin
            job.chars[1] = sextet_char({next_pend, 2'b00});
            job.cnt      = 2'd2;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      if (accept) begin
         phase_in = req_final_byte ? PH_0 : next_phase;
         pend_in  = req_final_byte ? 4'd0 : next_pend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         pend_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

   assign push     = accept;
   assign push_job = job;

`ifndef NO_ASSERTIONS
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |=> phase_ff == PH_0 && pend_ff == 4'd0)
      else $error("group state not cleared after final byte");
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("group phase reached unused code");
`endif

endmodule
`default_nettype wire

FILE: sv/b64e_queue.sv
`default_nettype none
module b64e_queue #(
   parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire b64e_pkg::b64e_job_type push_job,
   input  wire logic                   pop,
   output b64e_pkg::b64e_job_type      head_job,
   output b64e_pkg::b64e_qstat_type    qstat
);
   import b64e_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   b64e_job_type    entry_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == FullCnt);
   assign qstat.empty = (cnt_ff == '0);
   assign head_job    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full) && !(pop && qstat.empty))
      else $error("job queue overrun or underrun");
`endif

endmodule
`default_nettype wire

FILE: sv/b64e_back.sv
`default_nettype none
module b64e_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire b64e_pkg::b64e_job_type head_job,
   input  wire b64e_pkg::b64e_qstat_type qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_out_last
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       slot_free;
   logic       load;
   logic       at_end;

   assign slot_free = !valid_ff || rsp_ready;
   assign load      = slot_free && !qstat.empty;
   assign at_end    = (idx_ff == head_job.cnt);
   assign pop       = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = head_job.chars[idx_ff];
         last_in  = head_job.last && at_end;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

`ifndef NO_ASSERTIONS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      (!qstat.empty || idx_ff == 2'd0) && (qstat.empty || idx_ff <= head_job.cnt))
      else $error("character index outside current job");
`endif

endmodule
`default_nettype wire
